@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the escape-time checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset
`define MBE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge while reset is held
`define MBE_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) (!rst_n) |-> (prop)) else $error(msg);

`endif

@@ hw/rtl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Register and field widths
	localparam int REG_W     = 32;
	localparam int LIMIT_W   = 8;
	localparam int COORD_W   = 12;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REAL_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_START  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

	// Register reset values (Q4.28: -2.0, step, -1.5, step)
	localparam logic [REG_W-1:0]   RST_REAL_START = 32'hE000_0000;
	localparam logic [REG_W-1:0]   RST_REAL_STEP  = 32'd745654;
	localparam logic [REG_W-1:0]   RST_IMAG_START = 32'hE800_0000;
	localparam logic [REG_W-1:0]   RST_IMAG_STEP  = 32'd745654;
	localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 8'd20;

	// Default parameter values
	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_FRAC_BITS  = 28;

	// Entries in the queue between front and iteration unit
	localparam int QUEUE_DEPTH = 2;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hw/rtl/mbe_front.sv @@
// ----------------------------------------------------------------------------
// mbe_front
// Configuration registers, pixel intake and mapping of a pixel to c.
// ----------------------------------------------------------------------------
module mbe_front #(
	parameter int COORD_BITS = mbe_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbe_pkg::REG_W-1:0]         cfg_data,
	input  logic                              start,
	input  logic [mbe_pkg::COORD_W-1:0]       column,
	input  logic [mbe_pkg::COORD_W-1:0]       row,
	output logic                              busy,
	input  mbe_pkg::q_stat_t                  q_stat,
	output logic                              push,
	output logic [2*(COORD_BITS+34)-1:0]      push_data,
	output logic [mbe_pkg::LIMIT_W-1:0]       limit
);
	import mbe_pkg::*;

	// Index bits actually used, and width of a mapped coordinate
	localparam int UB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int CW = COORD_BITS + 34;

	logic [REG_W-1:0]       real_start_q;
	logic [REG_W-1:0]       real_step_q;
	logic [REG_W-1:0]       imag_start_q;
	logic [REG_W-1:0]       imag_step_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic                   pend_q;
	logic [UB-1:0]          col_q;
	logic [UB-1:0]          row_q;
	logic                   take;
	logic signed [CW-1:0]   cr_map;
	logic signed [CW-1:0]   ci_map;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_start_q <= RST_REAL_START;
			real_step_q  <= RST_REAL_STEP;
			imag_start_q <= RST_IMAG_START;
			imag_step_q  <= RST_IMAG_STEP;
			limit_q      <= RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REAL_START: real_start_q <= cfg_data;
				REG_REAL_STEP:  real_step_q  <= cfg_data;
				REG_IMAG_START: imag_start_q <= cfg_data;
				REG_IMAG_STEP:  imag_step_q  <= cfg_data;
				REG_ITER_LIMIT: limit_q      <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Intake: one pixel held until the queue takes it
	assign busy = pend_q && q_stat.full;
	assign take = start && !busy;
	assign push = pend_q && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (take) begin
			pend_q <= 1'b1;
		end else if (push) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q <= column[UB-1:0];
			row_q <= row[UB-1:0];
		end
	end

	// c = start + index * step on each axis, exact
	assign cr_map = CW'($signed(real_start_q))
		+ CW'($signed(real_step_q) * $signed({1'b0, col_q}));
	assign ci_map = CW'($signed(imag_start_q))
		+ CW'($signed(imag_step_q) * $signed({1'b0, row_q}));

	assign push_data = {cr_map, ci_map};
	assign limit     = limit_q;

endmodule

@@ hw/rtl/mbe_queue.sv @@
// ----------------------------------------------------------------------------
// mbe_queue
// Short first-in first-out queue of mapped points.
// ----------------------------------------------------------------------------
module mbe_queue #(
	parameter int WIDTH = 92,
	parameter int DEPTH = mbe_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output mbe_pkg::q_stat_t  q_stat
);
	import mbe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == NW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

@@ hw/rtl/mbe_core.sv @@
// ----------------------------------------------------------------------------
// mbe_core
// Iteration unit: z <- z*z + c, one update per clock, with escape test.
// ----------------------------------------------------------------------------
module mbe_core #(
	parameter int COORD_BITS = mbe_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mbe_pkg::LIMIT_W-1:0]    limit,
	input  mbe_pkg::q_stat_t               q_stat,
	input  logic [2*(COORD_BITS+34)-1:0]   q_data,
	output logic                           q_pop,
	output logic                           done,
	output logic [mbe_pkg::LIMIT_W-1:0]    iterations,
	output logic                           inside_res
);
	import mbe_pkg::*;

	// Widths: c, z (Q9.F), multiplier operand, and the update sum
	localparam int CW = COORD_BITS + 34;
	localparam int ZW = FRAC_BITS + 9;
	localparam int MW = FRAC_BITS + 3;
	localparam int PW = 2 * MW;
	localparam int SW = ((CW > ZW) ? CW : ZW) + 1;

	localparam logic signed [ZW-1:0] TWO   = ZW'(2) << FRAC_BITS;
	localparam logic signed [ZW-1:0] M_TWO = -TWO;
	localparam logic [PW:0]          FOUR  = (PW + 1)'(1) << (2 * FRAC_BITS + 2);
	localparam logic signed [SW-1:0] ZMAX  = (SW'(1) << (ZW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] ZMIN  = ~ZMAX;

	logic                    run_q;
	logic signed [CW-1:0]    cr_q;
	logic signed [CW-1:0]    ci_q;
	logic signed [ZW-1:0]    zr_q;
	logic signed [ZW-1:0]    zi_q;
	logic [LIMIT_W-1:0]      iter_q;
	logic                    done_q;
	logic [LIMIT_W-1:0]      iter_out_q;
	logic                    inside_q;

	logic signed [MW-1:0]    zr_m;
	logic signed [MW-1:0]    zi_m;
	logic signed [PW-1:0]    sq_r;
	logic signed [PW-1:0]    sq_i;
	logic signed [PW-1:0]    prod_ri;
	logic [PW:0]             mag_sq;
	logic signed [PW:0]      diff;
	logic signed [PW:0]      nr_full;
	logic signed [PW-1:0]    ni_full;
	logic signed [SW-1:0]    sum_r;
	logic signed [SW-1:0]    sum_i;
	logic signed [SW-1:0]    sat_r;
	logic signed [SW-1:0]    sat_i;
	logic                    esc;
	logic                    at_limit;
	logic                    finish;
	logic                    load;

	// Escape test: coarse range first, then |z|^2 > 4 at full precision
	assign zr_m    = zr_q[MW-1:0];
	assign zi_m    = zi_q[MW-1:0];
	assign sq_r    = zr_m * zr_m;
	assign sq_i    = zi_m * zi_m;
	assign prod_ri = zr_m * zi_m;
	assign mag_sq  = {1'b0, sq_r} + {1'b0, sq_i};
	assign esc = (zr_q > TWO) || (zr_q < M_TWO) || (zi_q > TWO) || (zi_q < M_TWO)
		|| (mag_sq > FOUR);

	// Next z: floor shifts of the products plus c, clamped to Q9.F
	assign diff    = {sq_r[PW-1], sq_r} - {sq_i[PW-1], sq_i};
	assign nr_full = diff >>> FRAC_BITS;
	assign ni_full = prod_ri >>> (FRAC_BITS - 1);
	assign sum_r   = SW'(nr_full) + SW'(cr_q);
	assign sum_i   = SW'(ni_full) + SW'(ci_q);
	assign sat_r   = (sum_r > ZMAX) ? ZMAX : ((sum_r < ZMIN) ? ZMIN : sum_r);
	assign sat_i   = (sum_i > ZMAX) ? ZMAX : ((sum_i < ZMIN) ? ZMIN : sum_i);

	// Limit is checked before the escape test
	assign at_limit = (iter_q >= limit);
	assign finish   = run_q && (at_limit || esc);
	assign load     = (!run_q || finish) && !q_stat.empty;
	assign q_pop    = load;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (load) begin
				run_q <= 1'b1;
			end else if (finish) begin
				run_q <= 1'b0;
			end
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		if (load) begin
			cr_q   <= $signed(q_data[2*CW-1:CW]);
			ci_q   <= $signed(q_data[CW-1:0]);
			zr_q   <= '0;
			zi_q   <= '0;
			iter_q <= '0;
		end else if (run_q && !finish) begin
			zr_q   <= sat_r[ZW-1:0];
			zi_q   <= sat_i[ZW-1:0];
			iter_q <= iter_q + 1'b1;
		end
		if (finish) begin
			iter_out_q <= iter_q;
			inside_q   <= (iter_q == limit);
		end
	end

	assign done       = done_q;
	assign iterations = iter_out_q;
	assign inside_res = inside_q;

endmodule

@@ hw/rtl/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel of a Mandelbrot view.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low. Its result appears
// for exactly one cycle with done high and cannot be held off, so the
// receiver must capture it then. The iteration unit does one z update per
// clock through three shared multipliers and holds each pixel until z
// escapes or the count reaches the iteration limit; that unit sets the
// throughput. On the way to done, a pixel is captured in the intake
// register, mapped to c and written into the queue, then loaded into the
// iteration unit and iterated, and its result is registered onto done.
// A two-entry queue behind the mapping stage lets up to three pixels wait
// while one iterates; busy rises only when all of them are taken.
// Configuration is meant to change only while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
	parameter int COORD_BITS = mbe_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbe_pkg::REG_W-1:0]      cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [mbe_pkg::COORD_W-1:0]    column,
	input  logic [mbe_pkg::COORD_W-1:0]    row,
	output logic                           done,
	output logic [mbe_pkg::LIMIT_W-1:0]    iterations,
	output logic                           inside_res
);
	import mbe_pkg::*;

	localparam int CW = COORD_BITS + 34;

	q_stat_t             q_stat;
	logic                push;
	logic [2*CW-1:0]     push_data;
	logic                pop;
	logic [2*CW-1:0]     pop_data;
	logic [LIMIT_W-1:0]  limit;

	// Intake and mapping
	mbe_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.column    (column),
		.row       (row),
		.busy      (busy),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data),
		.limit     (limit)
	);

	// Mapped points waiting for the iteration unit
	mbe_queue #(
		.WIDTH (2 * CW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Iteration unit
	mbe_core #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.limit      (limit),
		.q_stat     (q_stat),
		.q_data     (pop_data),
		.q_pop      (pop),
		.done       (done),
		.iterations (iterations),
		.inside_res (inside_res)
	);

endmodule

@@ hw/rtl/mbe_checker.sv @@
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbe_pkg::REG_W-1:0]      cfg_data,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           done,
	input  logic [mbe_pkg::LIMIT_W-1:0]    iterations,
	input  logic                           inside_res
);
	import mbe_pkg::*;

	logic [LIMIT_W-1:0] lim_q;
	logic [2:0]         pend_q;
	logic               accept;

	assign accept = start && !busy;

	// Shadow of the iteration limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= RST_ITER_LIMIT;
		end else if (cfg_we && (cfg_index == REG_ITER_LIMIT)) begin
			lim_q <= cfg_data[LIMIT_W-1:0];
		end
	end

	// Transactions accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({accept, done})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`MBE_ASSERT(a_done_has_item, clk, arst_n, done |-> (pend_q != 3'd0), "result without pixel")
	`MBE_ASSERT(a_busy_backlog, clk, arst_n, busy |-> (pend_q >= 3'd3), "busy with room left")
	`MBE_ASSERT(a_iter_le_limit, clk, arst_n, done |-> (iterations <= lim_q), "count over limit")
	`MBE_ASSERT(a_inside_at_limit, clk, arst_n, done |-> (inside_res == (iterations == lim_q)), "inside flag wrong")
	`MBE_ASSERT_IN_RST(a_quiet_in_reset, clk, arst_n, !done && !busy, "activity in reset")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.iterations (iterations),
	.inside_res (inside_res)
);
